/* hw/rtl/ckpc_pkg.sv */
// Shared types, constants and arithmetic helpers of the chroma-key compositor.
package ckpc_pkg;

	// Luma weights in Q0.16; they sum to one.
	localparam logic [23:0] Y_WR = 24'd19595;
	localparam logic [23:0] Y_WG = 24'd38470;
	localparam logic [23:0] Y_WB = 24'd7471;

	// Chroma scale factors in Q0.16.
	localparam logic [16:0] CB_COEF = 17'd36962;
	localparam logic [16:0] CR_COEF = 17'd46727;

	// Chroma offset of 128, placed at bit 32 of the scaled difference.
	localparam logic signed [43:0] CHROMA_BIAS = 44'sd549755813888;

	// Mask value that stands for 1.0 in Q1.8.
	localparam logic [8:0] MASK_ONE = 9'd256;

	// Square root of D * 2^16: 17 root bits, remainder below 2^33.
	localparam int SQ_ROOT_W = 17;
	localparam int SQ_REM_W  = 33;

	// Ramp quotient width and dividend width.
	localparam int DIV_Q_W   = 8;
	localparam int DIV_REM_W = 17;

	// Configuration register reset values.
	localparam logic [7:0]  RST_KEY_BLUE        = 8'd26;
	localparam logic [7:0]  RST_KEY_GREEN       = 8'd255;
	localparam logic [7:0]  RST_KEY_RED         = 8'd83;
	localparam logic [7:0]  RST_KEY_CHROMA_BLUE = 8'd42;
	localparam logic [7:0]  RST_KEY_CHROMA_RED  = 8'd60;
	localparam logic [15:0] RST_TOL_INNER       = 16'd46210;
	localparam logic [15:0] RST_TOL_OUTER       = 16'd46240;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_KEY_BLUE        = 3'd0,
		REG_KEY_GREEN       = 3'd1,
		REG_KEY_RED         = 3'd2,
		REG_KEY_CHROMA_BLUE = 3'd3,
		REG_KEY_CHROMA_RED  = 3'd4,
		REG_TOL_INNER       = 3'd5,
		REG_TOL_OUTER       = 3'd6
	} cfg_reg_t;

	// Foreground and background pixel carried down the pipeline.
	typedef struct packed {
		logic [7:0] fg_blue;
		logic [7:0] fg_green;
		logic [7:0] fg_red;
		logic [7:0] bg_blue;
		logic [7:0] bg_green;
		logic [7:0] bg_red;
	} pix_t;

	// Partial square root: root found so far and the remaining radicand.
	typedef struct packed {
		logic [SQ_ROOT_W-1:0] root;
		logic [SQ_REM_W-1:0]  rem;
	} sqrt_t;

	// Partial ramp division: quotient bits so far and the remainder.
	typedef struct packed {
		logic [DIV_Q_W-1:0]   quo;
		logic [DIV_REM_W-1:0] rem;
	} div_t;

	// Integer chroma of one component: floor(((c<<16) - y) * coef / 2^32 + 128), clamped.
	function automatic logic [7:0] chroma_of(logic [7:0] comp, logic [23:0] y,
			logic [16:0] coef);
		logic signed [24:0] diff;
		logic signed [43:0] v;
		logic [7:0] res;
		diff = $signed({1'b0, comp, 16'd0}) - $signed({1'b0, y});
		v = diff * $signed({1'b0, coef});
		v = v + CHROMA_BIAS;
		if (v[43]) begin
			res = 8'd0;
		end else if (|v[42:40]) begin
			res = 8'd255;
		end else begin
			res = v[39:32];
		end
		return res;
	endfunction

	// Digit-by-digit square root steps from root bit k_hi downwards.
	function automatic sqrt_t sqrt_steps(sqrt_t st, int k_hi, int count);
		sqrt_t r;
		logic [SQ_REM_W+1:0] trial;
		int k;
		r = st;
		for (int i = 0; i < count; i++) begin
			k = k_hi - i;
			trial = ({{(SQ_REM_W+2-SQ_ROOT_W){1'b0}}, r.root} << (k + 1))
				+ ({{(SQ_REM_W+1){1'b0}}, 1'b1} << (2 * k));
			if ({2'b00, r.rem} >= trial) begin
				r.rem  = r.rem - trial[SQ_REM_W-1:0];
				r.root = r.root | ({{(SQ_ROOT_W-1){1'b0}}, 1'b1} << k);
			end
		end
		return r;
	endfunction

	// Restoring division steps from quotient bit b_hi downwards.
	function automatic div_t div_steps(div_t st, logic [15:0] span, int b_hi, int count);
		div_t r;
		logic [23:0] trial;
		int b;
		r = st;
		for (int i = 0; i < count; i++) begin
			b = b_hi - i;
			trial = {8'd0, span} << b;
			if ({7'd0, r.rem} >= trial) begin
				r.rem = r.rem - trial[DIV_REM_W-1:0];
				r.quo = r.quo | ({{(DIV_Q_W-1){1'b0}}, 1'b1} << b);
			end
		end
		return r;
	endfunction

	// One output channel: max(fg*256 - mask*key, 0) + mask*bg, scaled down and saturated.
	function automatic logic [7:0] blend_ch(logic [7:0] fg, logic [7:0] bg, logic [7:0] key,
			logic [8:0] mask);
		logic [16:0] fg_sc;
		logic [16:0] mk;
		logic [16:0] mb;
		logic [16:0] keep;
		logic [16:0] sum;
		logic [7:0] res;
		fg_sc = {1'b0, fg, 8'd0};
		mk    = {8'd0, mask} * {9'd0, key};
		mb    = {8'd0, mask} * {9'd0, bg};
		keep  = (fg_sc > mk) ? (fg_sc - mk) : 17'd0;
		sum   = keep + mb;
		res   = sum[16] ? 8'd255 : sum[15:8];
		return res;
	endfunction

endpackage

/* hw/rtl/ckpc_ifs.sv */
// Valid/ready channel interfaces for the compositor's pixel input and output.
interface ckpc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] fg_blue;
	logic [7:0] fg_green;
	logic [7:0] fg_red;
	logic [7:0] bg_blue;
	logic [7:0] bg_green;
	logic [7:0] bg_red;

	modport source (
		output valid, fg_blue, fg_green, fg_red, bg_blue, bg_green, bg_red,
		input  ready
	);
	modport sink (
		input  valid, fg_blue, fg_green, fg_red, bg_blue, bg_green, bg_red,
		output ready
	);
endinterface

interface ckpc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_blue;
	logic [7:0] out_green;
	logic [7:0] out_red;

	modport source (
		output valid, out_blue, out_green, out_red,
		input  ready
	);
	modport sink (
		input  valid, out_blue, out_green, out_red,
		output ready
	);
endinterface

/* hw/rtl/chroma_key_pixel_compositor.sv */
// Chroma-key pixel compositor: eleven-stage pipeline, one pixel beat per clock.
// An accepted input beat passes through every stage register before its output beat is valid.
// Throughput is one pixel per cycle; the whole pipeline holds while the output beat waits.
// The 17-bit square root (five stages) and the 8-bit ramp division (two stages) set the depth.
// arst_n clears all valid bits and loads the configuration registers with their defaults.
module chroma_key_pixel_compositor (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_write,
	input  logic [2:0]       cfg_index,
	input  logic [15:0]      cfg_data,
	ckpc_in_if.sink          pixel_in,
	ckpc_out_if.source       pixel_out
);
	import ckpc_pkg::*;

	// Configuration registers.
	logic [7:0]  key_blue_q;
	logic [7:0]  key_green_q;
	logic [7:0]  key_red_q;
	logic [7:0]  key_cb_q;
	logic [7:0]  key_cr_q;
	logic [15:0] tol_inner_q;
	logic [15:0] tol_outer_q;

	// Pipeline control.
	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11;

	// Pipeline payload.
	pix_t        pix_s1, pix_s2, pix_s3, pix_s4, pix_s5, pix_s6, pix_s7, pix_s8, pix_s9;
	pix_t        pix_s10;
	logic [23:0] y_s1;
	logic [7:0]  cb_s2, cr_s2;
	logic [16:0] d_s3;
	logic        lt_in_s4, lt_in_s5, lt_in_s6, lt_in_s7, lt_in_s8, lt_in_s9;
	logic        lt_out_s4, lt_out_s5, lt_out_s6, lt_out_s7, lt_out_s8, lt_out_s9;
	sqrt_t       sq_s4, sq_s5, sq_s6, sq_s7;
	div_t        dv_s8, dv_s9;
	logic        sat_s8, sat_s9;
	logic [8:0]  mask_s10;
	logic [7:0]  out_blue_s11, out_green_s11, out_red_s11;

	// Combinational stage logic.
	logic [23:0] y_c;
	logic [8:0]  dcb_c, dcr_c;
	logic [17:0] sqb_c, sqr_c;
	logic [31:0] in2_c, out2_c;
	sqrt_t       sq_init_c;
	sqrt_t       sq_fin_c;
	logic [15:0] span_c;
	logic [23:0] base_c;
	logic [23:0] root_ext_c;
	logic [23:0] ramp_c;
	div_t        div_fin_c;
	logic [8:0]  alpha_c;

	// Configuration writes; an index beyond the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_blue_q  <= RST_KEY_BLUE;
			key_green_q <= RST_KEY_GREEN;
			key_red_q   <= RST_KEY_RED;
			key_cb_q    <= RST_KEY_CHROMA_BLUE;
			key_cr_q    <= RST_KEY_CHROMA_RED;
			tol_inner_q <= RST_TOL_INNER;
			tol_outer_q <= RST_TOL_OUTER;
		end else if (cfg_write) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_KEY_BLUE:        key_blue_q  <= cfg_data[7:0];
				REG_KEY_GREEN:       key_green_q <= cfg_data[7:0];
				REG_KEY_RED:         key_red_q   <= cfg_data[7:0];
				REG_KEY_CHROMA_BLUE: key_cb_q    <= cfg_data[7:0];
				REG_KEY_CHROMA_RED:  key_cr_q    <= cfg_data[7:0];
				REG_TOL_INNER:       tol_inner_q <= cfg_data;
				REG_TOL_OUTER:       tol_outer_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The pipeline moves as one whenever the output register is free or being emptied.
	assign adv            = !v_s11 || pixel_out.ready;
	assign pixel_in.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
		end else if (adv) begin
			v_s1  <= pixel_in.valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
		end
	end

	// Stage 1: luma of the foreground pixel in Q8.16.
	assign y_c = {16'd0, pixel_in.fg_red} * Y_WR + {16'd0, pixel_in.fg_green} * Y_WG
		+ {16'd0, pixel_in.fg_blue} * Y_WB;

	// Stage 3: squared chroma distance to the key.
	assign dcb_c = {1'b0, key_cb_q} - {1'b0, cb_s2};
	assign dcr_c = {1'b0, key_cr_q} - {1'b0, cr_s2};
	assign sqb_c = $signed(dcb_c) * $signed(dcb_c);
	assign sqr_c = $signed(dcr_c) * $signed(dcr_c);

	// Stage 4: tolerance squares for the region tests, and the start of the square root.
	assign in2_c     = {16'd0, tol_inner_q} * {16'd0, tol_inner_q};
	assign out2_c    = {16'd0, tol_outer_q} * {16'd0, tol_outer_q};
	assign sq_init_c = '{root: '0, rem: {d_s3, 16'd0}};

	// Stage 8: last root bit, then the offset of the distance into the ramp.
	assign sq_fin_c   = sqrt_steps(sq_s7, 0, 1);
	assign span_c     = tol_outer_q - tol_inner_q;
	assign base_c     = {tol_inner_q, 8'd0};
	assign root_ext_c = {{(24-SQ_ROOT_W){1'b0}}, sq_fin_c.root};
	assign ramp_c     = (root_ext_c > base_c) ? (root_ext_c - base_c) : 24'd0;

	// Stage 10: last quotient bits and the alpha value by region.
	assign div_fin_c = div_steps(dv_s9, span_c, 3, 4);
	always_comb begin
		priority if (lt_in_s9) begin
			alpha_c = 9'd0;
		end else if (lt_out_s9) begin
			alpha_c = sat_s9 ? 9'd255 : {1'b0, div_fin_c.quo};
		end else begin
			alpha_c = MASK_ONE;
		end
	end

	// Payload registers of all stages.
	always_ff @(posedge clk) begin
		if (adv) begin
			pix_s1 <= '{fg_blue: pixel_in.fg_blue, fg_green: pixel_in.fg_green,
				fg_red: pixel_in.fg_red, bg_blue: pixel_in.bg_blue,
				bg_green: pixel_in.bg_green, bg_red: pixel_in.bg_red};
			y_s1   <= y_c;

			pix_s2 <= pix_s1;
			cb_s2  <= chroma_of(pix_s1.fg_blue, y_s1, CB_COEF);
			cr_s2  <= chroma_of(pix_s1.fg_red, y_s1, CR_COEF);

			pix_s3 <= pix_s2;
			d_s3   <= {1'b0, sqb_c[15:0]} + {1'b0, sqr_c[15:0]};

			pix_s4    <= pix_s3;
			lt_in_s4  <= {15'd0, d_s3} < in2_c;
			lt_out_s4 <= {15'd0, d_s3} < out2_c;
			sq_s4     <= sqrt_steps(sq_init_c, 16, 4);

			pix_s5    <= pix_s4;
			lt_in_s5  <= lt_in_s4;
			lt_out_s5 <= lt_out_s4;
			sq_s5     <= sqrt_steps(sq_s4, 12, 4);

			pix_s6    <= pix_s5;
			lt_in_s6  <= lt_in_s5;
			lt_out_s6 <= lt_out_s5;
			sq_s6     <= sqrt_steps(sq_s5, 8, 4);

			pix_s7    <= pix_s6;
			lt_in_s7  <= lt_in_s6;
			lt_out_s7 <= lt_out_s6;
			sq_s7     <= sqrt_steps(sq_s6, 4, 4);

			pix_s8    <= pix_s7;
			lt_in_s8  <= lt_in_s7;
			lt_out_s8 <= lt_out_s7;
			dv_s8     <= '{quo: '0, rem: ramp_c[DIV_REM_W-1:0]};
			sat_s8    <= ramp_c >= {span_c, 8'd0};

			pix_s9    <= pix_s8;
			lt_in_s9  <= lt_in_s8;
			lt_out_s9 <= lt_out_s8;
			dv_s9     <= div_steps(dv_s8, span_c, 7, 4);
			sat_s9    <= sat_s8;

			pix_s10  <= pix_s9;
			mask_s10 <= MASK_ONE - alpha_c;

			out_blue_s11  <= blend_ch(pix_s10.fg_blue, pix_s10.bg_blue, key_blue_q, mask_s10);
			out_green_s11 <= blend_ch(pix_s10.fg_green, pix_s10.bg_green, key_green_q,
				mask_s10);
			out_red_s11   <= blend_ch(pix_s10.fg_red, pix_s10.bg_red, key_red_q, mask_s10);
		end
	end

	// Output beat.
	assign pixel_out.valid     = v_s11;
	assign pixel_out.out_blue  = out_blue_s11;
	assign pixel_out.out_green = out_green_s11;
	assign pixel_out.out_red   = out_red_s11;

`ifndef SYNTH
	// An accepted beat always lands in the first stage.
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(pixel_in.valid && pixel_in.ready) |=> v_s1)
		else $error("accepted beat did not enter stage 1");

	// The finished root leaves a remainder no larger than twice the root.
	a_sqrt_exact: assert property (@(posedge clk) disable iff (!arst_n)
		v_s7 |-> ({1'b0, sq_fin_c.rem} <= {{(SQ_REM_W-SQ_ROOT_W){1'b0}}, sq_fin_c.root, 1'b0}))
		else $error("square root remainder out of range");

	// On the ramp, an unsaturated quotient leaves a remainder below the span.
	a_div_exact: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s9 && !lt_in_s9 && lt_out_s9 && !sat_s9)
		|-> (div_fin_c.rem < {1'b0, span_c}))
		else $error("ramp division remainder not below the span");

	// A pixel inside the inner tolerance is fully keyed out.
	a_inner_mask: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s9 && lt_in_s9 && adv) |=> (mask_s10 == MASK_ONE))
		else $error("inner-tolerance pixel did not get a full mask");
`endif

endmodule
